>>> sv/dpf_pkg.sv
// Shared types and constants for the distinct prime factor block.
`timescale 1ns / 1ps

package dpf_pkg;

  // Fixed widths of the channel fields
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned FACTOR_W = 32;

  // Trial division starts here
  localparam int unsigned FIRST_DIVISOR = 2;

  typedef logic [VALUE_W-1:0]  value_t;
  typedef logic [FACTOR_W-1:0] factor_t;

endpackage : dpf_pkg

>>> sv/dpf_if.sv
// Valid/ready channel interfaces for the input value and the factor results.
`timescale 1ns / 1ps

interface dpf_in_if import dpf_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface : dpf_in_if

interface dpf_out_if import dpf_pkg::*; ();
  logic    valid;
  logic    ready;
  factor_t factor;
  logic    last;
  logic    none_found;

  modport source (output valid, output factor, output last, output none_found, input ready);
  modport sink   (input valid, input factor, input last, input none_found, output ready);
endinterface : dpf_out_if

>>> sv/dpf_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module dpf_div import dpf_pkg::*; #(
  parameter int unsigned W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quo,
  output logic [W-1:0] rem
);

  localparam int unsigned CW = $clog2(W + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  dq_r, dq_nxt;     // dividend in, quotient out
  logic [W-1:0]  part_r, part_nxt; // partial remainder
  logic [W-1:0]  dvs_r, dvs_nxt;

  logic [W:0]    trial;
  logic          ge;
  logic [W:0]    diff;

  assign trial = {part_r, dq_r[W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dq_nxt   = dq_r;
    part_nxt = part_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(W);
      dq_nxt   = dividend;
      part_nxt = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      part_nxt = ge ? diff[W-1:0] : trial[W-1:0];
      dq_nxt   = {dq_r[W-2:0], ge};
      cnt_nxt  = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r   <= dq_nxt;
    part_r <= part_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign done = done_r;
  assign quo  = dq_r;
  assign rem  = part_r;

endmodule : dpf_div

>>> sv/distinct_prime_factors_top.sv
// Top level: distinct prime factors of one value by trial division.
`timescale 1ns / 1ps
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+----------------------------------
//  in_ch    | in  | valid/ready, beat on   | value (32b, low DW bits used)
//           |     | valid & ready          |
//  out_ch   | out | valid/ready, beat on   | factor (32b), last, none_found
//           |     | valid & ready          |
//
//  Flow: one value at a time. Each trial divisor runs the bit-serial divider
//  (one quotient bit per cycle, DW = data width) once, plus once more for
//  every time the factor divides out. A 32-bit prime runs about 65536
//  divisors.
//  Reset: synchronous, active low, clears control only; no clearing pass.
//  Stalls: one output register; the search pauses only when a new beat is
//  due while the previous one has not been taken.

module distinct_prime_factors_top import dpf_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  dpf_in_if.sink    in_ch,
  dpf_out_if.source out_ch
);

  // Datapath width: input field is 32 bits, masked further by VALUE_WIDTH
  localparam int unsigned DW = (VALUE_WIDTH < VALUE_W) ? VALUE_WIDTH : VALUE_W;
  // Square of divisor can pass 2^DW by a little before the loop exits
  localparam int unsigned SW = DW + 2;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1; // d*d <= rem ?
  localparam logic [2:0] S_START = 3'd2; // launch rem / d
  localparam logic [2:0] S_DIV   = 3'd3; // wait on divider
  localparam logic [2:0] S_NEXT  = 3'd4; // record factor, step d
  localparam logic [2:0] S_FIN   = 3'd5; // flush pending factor and leftover

  logic [2:0]    state_r, state_nxt;
  logic [DW-1:0] rem_r, rem_nxt;   // remaining value
  logic [DW-1:0] d_r, d_nxt;       // trial divisor
  logic [SW-1:0] sq_r, sq_nxt;     // d squared, kept incrementally
  logic [DW-1:0] pend_r, pend_nxt; // last factor found, not yet sent
  logic          pend_vld_r, pend_vld_nxt;
  logic          fnd_r, fnd_nxt;   // current d divided at least once

  logic          out_vld_r, out_vld_nxt;
  factor_t       out_factor_r;
  logic          out_last_r;
  logic          out_none_r;

  logic          out_free;
  logic          emit;
  logic [DW-1:0] emit_factor;
  logic          emit_last;
  logic          emit_none;

  logic          div_start;
  logic          div_done;
  logic [DW-1:0] div_quo;
  logic [DW-1:0] div_rem;

  dpf_div #(.W(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rem_r),
    .divisor  (d_r),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  assign out_free    = !out_vld_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    rem_nxt      = rem_r;
    d_nxt        = d_r;
    sq_nxt       = sq_r;
    pend_nxt     = pend_r;
    pend_vld_nxt = pend_vld_r;
    fnd_nxt      = fnd_r;
    div_start    = 1'b0;
    emit         = 1'b0;
    emit_factor  = '0;
    emit_last    = 1'b0;
    emit_none    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          rem_nxt      = in_ch.value[DW-1:0];
          d_nxt        = DW'(FIRST_DIVISOR);
          sq_nxt       = SW'(FIRST_DIVISOR * FIRST_DIVISOR);
          pend_vld_nxt = 1'b0;
          fnd_nxt      = 1'b0;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        // values below 2 fail here at once and end in the no-factor beat
        state_nxt = (sq_r <= SW'(rem_r)) ? S_START : S_FIN;
      end
      S_START: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          if (div_rem == '0) begin
            // divides: take it out and try the same d again
            rem_nxt   = div_quo;
            fnd_nxt   = 1'b1;
            state_nxt = S_START;
          end else begin
            state_nxt = S_NEXT;
          end
        end
      end
      S_NEXT: begin
        if (!fnd_r || !pend_vld_r || out_free) begin
          if (fnd_r) begin
            emit         = pend_vld_r;
            emit_factor  = pend_r;
            pend_nxt     = d_r;
            pend_vld_nxt = 1'b1;
          end
          fnd_nxt   = 1'b0;
          d_nxt     = d_r + DW'(1);
          sq_nxt    = sq_r + SW'({d_r, 1'b1}); // (d+1)^2 = d^2 + 2d + 1
          state_nxt = S_CHECK;
        end
      end
      S_FIN: begin
        if (out_free) begin
          emit = 1'b1;
          if (rem_r > DW'(1)) begin
            if (pend_vld_r) begin
              emit_factor  = pend_r;
              pend_vld_nxt = 1'b0;
            end else begin
              // leftover above 1 is the largest prime
              emit_factor = rem_r;
              emit_last   = 1'b1;
              state_nxt   = S_IDLE;
            end
          end else begin
            emit_factor = pend_r;
            emit_last   = 1'b1;
            emit_none   = !pend_vld_r;
            if (!pend_vld_r) begin
              emit_factor = '0;
            end
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (emit) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      pend_vld_r <= 1'b0;
      fnd_r      <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pend_vld_r <= pend_vld_nxt;
      fnd_r      <= fnd_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    d_r    <= d_nxt;
    sq_r   <= sq_nxt;
    pend_r <= pend_nxt;
    if (emit) begin
      out_factor_r <= FACTOR_W'(emit_factor);
      out_last_r   <= emit_last;
      out_none_r   <= emit_none;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.factor     = out_factor_r;
  assign out_ch.last       = out_last_r;
  assign out_ch.none_found = out_none_r;

endmodule : distinct_prime_factors_top

>>> sv/dpf_chk.sv
// Port-level checker for the distinct prime factor block, bound to the top.
`timescale 1ns / 1ps

module dpf_chk import dpf_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input factor_t out_factor,
  input logic    out_last,
  input logic    out_none_found
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_factor) && $stable(out_last))
    else $error("stalled result beat changed");

  // no-factor beat is last and carries zero
  a_none_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_none_found |-> out_last && (out_factor == '0))
    else $error("malformed no-factor beat");

  // one value at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // a non-last result is waiting, so more are due: no new value yet
  a_mid_list: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready before last result");

endmodule : dpf_chk

bind distinct_prime_factors_top dpf_chk u_dpf_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_factor     (out_ch.factor),
  .out_last       (out_ch.last),
  .out_none_found (out_ch.none_found)
);

>>> sim/dpf_factor_checker.sv
// Prime factor predictor and result scoreboard for the distinct prime factor block.
`timescale 1ns / 1ps

module dpf_factor_checker import dpf_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned MAX_FACTORS = 9
) (
  input  logic        clk,
  input  logic        rst_n,
  dpf_in_if           in_ch,
  dpf_out_if          out_ch,
  output int unsigned fail_count,
  output int unsigned pending
);

  typedef struct {
    value_t  src;
    factor_t factor;
    logic    last;
    logic    none_found;
  } factor_beat_t;

  factor_beat_t expected_factors[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] factor check: %s", $time, msg);
    fail_count++;
  endtask

  // Trial division on the masked value; queues one beat per distinct prime, or one no-factor beat below 2.
  function automatic void predict_factors(input value_t v);
    longint unsigned rem;
    longint unsigned divisor;
    longint unsigned found[$];
    factor_beat_t    beat;
    rem = 64'(v) & ((64'd1 << VALUE_WIDTH) - 64'd1);
    beat.src = v;
    if (rem < 2) begin
      beat.factor     = '0;
      beat.last       = 1'b1;
      beat.none_found = 1'b1;
      expected_factors.push_back(beat);
      return;
    end
    for (divisor = FIRST_DIVISOR; divisor * divisor <= rem; divisor++) begin
      if (rem % divisor == 0) begin
        while (rem % divisor == 0) rem = rem / divisor;
        if (found.size() < MAX_FACTORS) found.push_back(divisor);
      end
    end
    if (rem > 1 && found.size() < MAX_FACTORS) found.push_back(rem);
    foreach (found[i]) begin
      beat.factor     = factor_t'(found[i]);
      beat.last       = (i == found.size() - 1);
      beat.none_found = 1'b0;
      expected_factors.push_back(beat);
    end
  endfunction

  always @(posedge clk) begin : check_beats
    factor_beat_t want;
    if (rst_n) begin
      // result side first: a beat taken on this edge belongs to an older value
      if (out_ch.valid && out_ch.ready) begin
        if (expected_factors.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat: factor %0d last %b none %b",
                                    out_ch.factor, out_ch.last, out_ch.none_found));
        end else begin
          want = expected_factors.pop_front();
          if (out_ch.factor !== want.factor)
            report_mismatch($sformatf("value %0d: factor %0d, want %0d",
                                      want.src, out_ch.factor, want.factor));
          if (out_ch.last !== want.last)
            report_mismatch($sformatf("value %0d factor %0d: last %b, want %b",
                                      want.src, want.factor, out_ch.last, want.last));
          if (out_ch.none_found !== want.none_found)
            report_mismatch($sformatf("value %0d factor %0d: none_found %b, want %b",
                                      want.src, want.factor, out_ch.none_found,
                                      want.none_found));
        end
      end
      if (in_ch.valid && in_ch.ready) predict_factors(in_ch.value);
    end
    pending = expected_factors.size();
  end

endmodule : dpf_factor_checker

>>> sim/distinct_prime_factors_top_tb.sv
// Testbench top for distinct_prime_factors_top: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module distinct_prime_factors_top_tb;
  import dpf_pkg::*;

  localparam int unsigned RANDOM_VALUES  = 100;
  localparam int unsigned HOLDOFF_CYCLES = 600;
  localparam int unsigned DRAIN_CYCLES   = 200;
  // The run limit is 20 ms of simulated time at the 2 ns clock period.
  localparam longint unsigned RUN_LIMIT_NS = 20_000_000;

  // Receiver flow-control patterns, picked per segment
  typedef enum int {
    RX_OPEN,    // always ready
    RX_COIN,    // ready half the time
    RX_SPARSE,  // ready one cycle in four
    RX_BUSY     // ready with probability 7/8
  } rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned result_beats;
  int unsigned burst_left;

  // Small primes for building smooth values: large, but cheap to factor
  int unsigned small_primes [0:29] = '{
    2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47,
    53, 59, 61, 67, 71, 73, 79, 83, 89, 97, 101, 103, 107, 109, 113
  };

  // Directed values: no-factor inputs, tiny primes, prime squares (divisor
  // squared equal to the remainder), primes up to 2^20, the 9-prime maximum,
  // high powers of one prime, and all-ones / alternating bit patterns.
  value_t directed_values [0:22] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd12, 32'd25, 32'd49,
    32'd169, 32'd97, 32'd65521, 32'd1048573, 32'd30030, 32'd9699690,
    32'd223092870, 32'hFFFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA,
    32'h5555_5555, 32'hFFFF_0000, 32'd3486784401, 32'h0001_0000
  };

  dpf_in_if  in_ch ();
  dpf_out_if out_ch ();

  always #1 clk = ~clk;

  distinct_prime_factors_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  dpf_factor_checker u_factor_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // result beat count, used to time the receiver hold-offs
  always @(posedge clk) begin
    if (!rst_n) begin
      result_beats <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      result_beats <= result_beats + 1;
    end
  end

  // Product of random small primes: fills the high bits, factors fast.
  function automatic value_t smooth_value();
    longint unsigned acc;
    longint unsigned p;
    int unsigned     n;
    acc = 1;
    n = $urandom_range(2, 14);
    repeat (n) begin
      p = small_primes[$urandom_range(0, 29)];
      if (acc * p <= 64'hFFFF_FFFF) acc = acc * p;
    end
    return value_t'(acc);
  endfunction

  // Offer one value; called at a falling edge, returns at a falling edge.
  // Bursts of back-to-back beats, random gaps between bursts.
  task automatic send_value(input value_t v);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    in_ch.valid = 1'b1;
    in_ch.value = v;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    burst_left--;
  endtask

  // Receiver: random ready pattern in segments, plus two long hold-offs
  // that back the block up until it stops taking values.
  initial begin : receiver
    rx_mode_t    mode;
    int unsigned seg_len;
    int unsigned holdoffs;
    holdoffs     = 0;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if ((holdoffs == 0 && result_beats >= 8) || (holdoffs == 1 && result_beats >= 60)) begin
        holdoffs++;
        out_ch.ready = 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
      end
      mode    = rx_mode_t'($urandom_range(0, 3));
      seg_len = $urandom_range(4, 64);
      repeat (seg_len) begin
        case (mode)
          RX_OPEN:   out_ch.ready = 1'b1;
          RX_COIN:   out_ch.ready = $urandom_range(0, 1);
          RX_SPARSE: out_ch.ready = ($urandom_range(0, 3) == 0);
          RX_BUSY:   out_ch.ready = ($urandom_range(0, 7) != 0);
          default:   out_ch.ready = 1'b1;
        endcase
        @(negedge clk);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    burst_left  = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_values[i]) send_value(directed_values[i]);

    // mostly cheap values; medium range reaches primes up to 2^16,
    // smooth products cover the upper bits
    repeat (RANDOM_VALUES) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: send_value(value_t'($urandom_range(0, 4095)));
        6, 7:             send_value(value_t'($urandom_range(0, 65535)));
        default:          send_value(smooth_value());
      endcase
    end
    in_ch.valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("** distinct_prime_factors_top: PASSED **");
    end else begin
      $display("** distinct_prime_factors_top: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("** distinct_prime_factors_top: FAILED **");
    $finish;
  end

endmodule : distinct_prime_factors_top_tb
